// File: rtl/core/deq_pkg.sv
package deq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned ErrW   = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_PUSH_LEFT  = 3'd0,
    MODE_PUSH_RIGHT = 3'd1,
    MODE_POP_LEFT   = 3'd2,
    MODE_POP_RIGHT  = 3'd3,
    MODE_CLEAR      = 3'd4
  } mode_e;

  typedef enum logic [ErrW-1:0] {
    ERR_OK        = 2'd0,
    ERR_POP_EMPTY = 2'd1,
    ERR_PUSH_FULL = 2'd2
  } err_e;

  // what a whole chain does on each clock edge
  typedef enum logic [1:0] {
    CHAIN_HOLD,
    CHAIN_INSERT,  // shift toward the tail, new value enters at the head
    CHAIN_REMOVE,  // shift toward the head, head element drops out
    CHAIN_APPEND   // write new value into the cell just past the tail
  } chain_op_e;

  // what a single cell does on each clock edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_PREV,
    CELL_FROM_NEXT,
    CELL_LOAD
  } cell_op_e;

endpackage

// File: rtl/core/deq_cell.sv
module deq_cell #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  deq_pkg::cell_op_e     op_i,
  input  logic [DATA_WIDTH-1:0] prev_i,
  input  logic [DATA_WIDTH-1:0] next_i,
  input  logic [DATA_WIDTH-1:0] load_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    unique case (op_i)
      deq_pkg::CELL_FROM_PREV: data_d = prev_i;
      deq_pkg::CELL_FROM_NEXT: data_d = next_i;
      deq_pkg::CELL_LOAD:      data_d = load_i;
      default:                 data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: rtl/core/deq_chain.sv
module deq_chain #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  deq_pkg::chain_op_e    op_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  output logic [DATA_WIDTH-1:0] head_o
);

  logic [DATA_WIDTH-1:0] data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    deq_pkg::cell_op_e     cell_op;
    logic [DATA_WIDTH-1:0] prev_data;
    logic [DATA_WIDTH-1:0] next_data;

    if (i == 0) begin : g_first
      assign prev_data = value_i;
    end else begin : g_mid_prev
      assign prev_data = data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_data = data[i];
    end else begin : g_mid_next
      assign next_data = data[i+1];
    end

    // append targets only the cell whose position equals the fill level
    always_comb begin
      unique case (op_i)
        deq_pkg::CHAIN_INSERT: cell_op = deq_pkg::CELL_FROM_PREV;
        deq_pkg::CHAIN_REMOVE: cell_op = deq_pkg::CELL_FROM_NEXT;
        deq_pkg::CHAIN_APPEND: cell_op = (count_i == CNT_W'(i)) ? deq_pkg::CELL_LOAD
                                                                : deq_pkg::CELL_HOLD;
        default:               cell_op = deq_pkg::CELL_HOLD;
      endcase
    end

    deq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .op_i   (cell_op),
      .prev_i (prev_data),
      .next_i (next_data),
      .load_i (value_i),
      .data_o (data[i])
    );
  end

  assign head_o = data[0];

endmodule

// File: rtl/core/double_ended_queue.sv
// Double-ended queue built from two rows of shift cells, one ordered from the left end and
// one from the right end, so both ends always sit in cell zero of their row.
// Latency: the result of an operation is presented the cycle after it is accepted.
// Throughput: one operation per cycle while out_stall_i is low; each cell only shifts, loads or holds per cycle.
// Reset: count and error clear, the queue reads as empty; cell contents are not reset.
module double_ended_queue #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [deq_pkg::ModeW-1:0]           mode_i,
  input  logic signed [deq_pkg::ValueW-1:0]   value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [deq_pkg::ValueW-1:0]   left_value_o,
  output logic signed [deq_pkg::ValueW-1:0]   right_value_o,
  output logic [$clog2(DEPTH + 1)-1:0]        count_o,
  output logic                                empty_res_o,
  output logic [deq_pkg::ErrW-1:0]            error_o
);

  localparam int unsigned VW    = deq_pkg::ValueW;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]      count_q, count_d;
  deq_pkg::err_e         err_q, err_d;
  logic                  out_valid_q;
  logic                  accept;
  logic                  full, empty;
  logic [DATA_WIDTH-1:0] value_st;
  logic [DATA_WIDTH-1:0] left_head, right_head;
  deq_pkg::chain_op_e    left_op, right_op;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);

  // stored form: sign-extended input kept to DATA_WIDTH bits
  if (DATA_WIDTH <= VW) begin : g_in_narrow
    assign value_st = value_i[DATA_WIDTH-1:0];
  end else begin : g_in_wide
    assign value_st = {{(DATA_WIDTH - VW){value_i[VW-1]}}, value_i};
  end

  always_comb begin
    left_op  = deq_pkg::CHAIN_HOLD;
    right_op = deq_pkg::CHAIN_HOLD;
    count_d  = count_q;
    err_d    = deq_pkg::ERR_OK;
    if (accept) begin
      unique case (mode_i)
        deq_pkg::MODE_PUSH_LEFT: begin
          if (full) begin
            err_d = deq_pkg::ERR_PUSH_FULL;
          end else begin
            left_op  = deq_pkg::CHAIN_INSERT;
            right_op = deq_pkg::CHAIN_APPEND;
            count_d  = count_q + 1'b1;
          end
        end
        deq_pkg::MODE_PUSH_RIGHT: begin
          if (full) begin
            err_d = deq_pkg::ERR_PUSH_FULL;
          end else begin
            left_op  = deq_pkg::CHAIN_APPEND;
            right_op = deq_pkg::CHAIN_INSERT;
            count_d  = count_q + 1'b1;
          end
        end
        deq_pkg::MODE_POP_LEFT: begin
          if (empty) begin
            err_d = deq_pkg::ERR_POP_EMPTY;
          end else begin
            left_op = deq_pkg::CHAIN_REMOVE;
            count_d = count_q - 1'b1;
          end
        end
        deq_pkg::MODE_POP_RIGHT: begin
          if (empty) begin
            err_d = deq_pkg::ERR_POP_EMPTY;
          end else begin
            right_op = deq_pkg::CHAIN_REMOVE;
            count_d  = count_q - 1'b1;
          end
        end
        deq_pkg::MODE_CLEAR: begin
          count_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      err_q       <= deq_pkg::ERR_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
        err_q   <= err_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  deq_chain #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH),
    .CNT_W     (CNT_W)
  ) u_left_chain (
    .clk_i   (clk_i),
    .op_i    (left_op),
    .count_i (count_q),
    .value_i (value_st),
    .head_o  (left_head)
  );

  deq_chain #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH),
    .CNT_W     (CNT_W)
  ) u_right_chain (
    .clk_i   (clk_i),
    .op_i    (right_op),
    .count_i (count_q),
    .value_i (value_st),
    .head_o  (right_head)
  );

  // state is frozen while a result waits, so the heads serve as the result register
  if (DATA_WIDTH >= VW) begin : g_out_wide
    assign left_value_o  = empty ? '0 : left_head[VW-1:0];
    assign right_value_o = empty ? '0 : right_head[VW-1:0];
  end else begin : g_out_narrow
    assign left_value_o  = empty ? '0 : {{(VW - DATA_WIDTH){1'b0}}, left_head};
    assign right_value_o = empty ? '0 : {{(VW - DATA_WIDTH){1'b0}}, right_head};
  end

  assign out_valid_o = out_valid_q;
  assign count_o     = count_q;
  assign empty_res_o = empty;
  assign error_o     = err_q;

endmodule
